FILE: rtl/bmhq_pkg.sv
`default_nettype none

package bmhq_pkg;

	// field widths of the request and result words
	localparam int unsigned VALUE_W = 32;
	localparam int unsigned COUNT_W = 8;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_e;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_e;

	typedef struct packed {
		op_e                        cmd;
		logic signed [VALUE_W-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0]  top_value;
		logic [COUNT_W-1:0]         entry_count;
		logic                       is_empty;
		err_e                       error_code;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic ins_load;     // open an insert: pos at end, count up, latch value
		logic del_load;     // open a delete: count down
		logic err_set;      // refuse the word, record err_code
		err_e err_code;
		logic rd_parent;    // read parent of pos
		logic rd_last;      // read last entry
		logic last_load;    // take last entry as moving value, pos to root
		logic rd_children;  // read both children of pos
		logic wr_val;       // write moving value at pos
		logic wr_parent;    // move parent down to pos, pos to parent
		logic wr_big;       // move larger child up to pos, pos to that child
	} ctl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
		logic one_left;
		logic pos_zero;
		logic up_less;      // parent smaller than moving value
		logic left_valid;   // left child of pos is a live entry
		logic down_less;    // moving value smaller than larger child
	} ctl_sts_t;

endpackage

`default_nettype wire

FILE: rtl/binary_max_heap_queue_core.sv
`default_nettype none

// Max-priority queue of up to DEPTH signed DATA_WIDTH-bit values, held as an
// array binary heap in a two-read, one-write RAM. A word is taken at a rising
// edge with start high and busy low; cmd selects insert of value or delete of
// the maximum. Every word gives exactly one result, shown on result for the
// single cycle in which done is high; the receiver cannot stall, so it must
// take result in that cycle. A new word may be started in the done cycle.
// The sift loop walks the heap one level at a time: a RAM read step, then a
// compare-and-write step. An insert climbs the value up until it reaches the
// root or stops below a parent; a delete moves the last entry to the root
// and sinks it until it reaches a leaf or stops above its children (at most
// ceil(log2(DEPTH)) levels either way). Refused words and a delete of the
// last entry go straight to done without a heap walk. No clearing pass
// after reset: the store is only ever read at live positions.
module binary_max_heap_queue_core #(
	parameter int unsigned DEPTH      = 128,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	input  wire bmhq_pkg::req_t  request,
	output      logic            busy,
	output      logic            done,
	output      bmhq_pkg::rsp_t  result
);

	// command and status between sequencer and datapath
	bmhq_pkg::ctl_cmd_t ctl_cmd;
	bmhq_pkg::ctl_sts_t ctl_sts;

	// sequencer: accepts words, walks the heap one level at a time
	bmhq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (request.cmd),
		.sts    (ctl_sts),
		.cmd    (ctl_cmd),
		.busy   (busy),
		.done   (done)
	);

	// datapath: heap RAM, fill count, position, moving value, root copy
	bmhq_dp #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_value (request.value),
		.cmd       (ctl_cmd),
		.sts       (ctl_sts),
		.rsp       (result)
	);

endmodule

`default_nettype wire

FILE: rtl/bmhq_ram.sv
`default_nettype none

// one write port, two read ports, registered read data
module bmhq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output      logic [WIDTH-1:0]         rdata_a,
	output      logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

`default_nettype wire

FILE: rtl/bmhq_dp.sv
`default_nettype none

module bmhq_dp #(
	parameter int unsigned DEPTH      = 128,
	parameter int unsigned DATA_WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic signed [bmhq_pkg::VALUE_W-1:0]  req_value,
	input  wire bmhq_pkg::ctl_cmd_t                   cmd,
	output      bmhq_pkg::ctl_sts_t                   sts,
	output      bmhq_pkg::rsp_t                       rsp
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned IW = AW + 2;

	logic [CW-1:0]          count_q;
	logic [AW-1:0]          pos_q;
	logic [DATA_WIDTH-1:0]  val_q;
	logic [DATA_WIDTH-1:0]  root_q;
	bmhq_pkg::err_e         err_q;

	logic signed [63:0]     in_ext;
	logic signed [63:0]     root_ext;
	logic [31:0]            count_ext;
	logic [AW-1:0]          parent_idx;
	logic [IW-1:0]          left_idx;
	logic [IW-1:0]          right_idx;
	logic [IW-1:0]          count_w;
	logic                   right_valid;
	logic                   right_wins;
	logic [IW-1:0]          big_idx;
	logic [DATA_WIDTH-1:0]  big_val;

	logic                   we;
	logic [AW-1:0]          waddr;
	logic [DATA_WIDTH-1:0]  wdata;
	logic [AW-1:0]          raddr_a;
	logic [DATA_WIDTH-1:0]  rdata_a;
	logic [DATA_WIDTH-1:0]  rdata_b;

	assign in_ext     = 64'(req_value);
	assign parent_idx = AW'((pos_q - 1'b1) >> 1);
	assign left_idx   = IW'({pos_q, 1'b1});
	assign right_idx  = left_idx + 1'b1;
	assign count_w    = IW'(count_q);

	assign right_valid = right_idx < count_w;
	assign right_wins  = right_valid && !($signed(rdata_b) < $signed(rdata_a));
	assign big_idx     = right_wins ? right_idx : left_idx;
	assign big_val     = right_wins ? rdata_b : rdata_a;

	assign raddr_a = cmd.rd_last     ? count_q[AW-1:0] :
	                 cmd.rd_children ? left_idx[AW-1:0] :
	                 cmd.rd_parent   ? parent_idx : '0;

	assign we    = cmd.wr_val | cmd.wr_parent | cmd.wr_big;
	assign waddr = pos_q;
	assign wdata = cmd.wr_parent ? rdata_a : (cmd.wr_big ? big_val : val_q);

	bmhq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (right_idx[AW-1:0]),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pos_q   <= '0;
			err_q   <= bmhq_pkg::ERR_OK;
		end else begin
			if (cmd.ins_load) begin
				pos_q   <= count_q[AW-1:0];
				count_q <= count_q + 1'b1;
				err_q   <= bmhq_pkg::ERR_OK;
			end else if (cmd.del_load) begin
				count_q <= count_q - 1'b1;
				err_q   <= bmhq_pkg::ERR_OK;
			end else if (cmd.err_set) begin
				err_q   <= cmd.err_code;
			end
			if (cmd.wr_parent) begin
				pos_q <= parent_idx;
			end else if (cmd.wr_big) begin
				pos_q <= big_idx[AW-1:0];
			end else if (cmd.last_load) begin
				pos_q <= '0;
			end
		end
	end

	// moving value and a copy of the root entry
	always_ff @(posedge clk) begin
		if (cmd.ins_load) begin
			val_q <= in_ext[DATA_WIDTH-1:0];
		end else if (cmd.last_load) begin
			val_q <= rdata_a;
		end
		if (we && (waddr == '0)) begin
			root_q <= wdata;
		end
	end

	always_comb begin
		sts.full       = count_q == CW'(DEPTH);
		sts.empty      = count_q == '0;
		sts.one_left   = count_q == CW'(1);
		sts.pos_zero   = pos_q == '0;
		sts.up_less    = $signed(rdata_a) < $signed(val_q);
		sts.left_valid = left_idx < count_w;
		sts.down_less  = $signed(val_q) < $signed(big_val);
	end

	assign root_ext  = 64'($signed(root_q));
	assign count_ext = 32'(count_q);

	always_comb begin
		rsp.top_value   = (count_q == '0) ? '0 : root_ext[bmhq_pkg::VALUE_W-1:0];
		rsp.entry_count = count_ext[bmhq_pkg::COUNT_W-1:0];
		rsp.is_empty    = count_q == '0;
		rsp.error_code  = err_q;
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond depth");

	a_write_live: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (CW'(pos_q) < count_q))
		else $error("write outside the live entries");

	a_root_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(we && (waddr == '0)) |=> (root_q == $past(wdata)))
		else $error("root copy missed a write to the root");

endmodule

`default_nettype wire

FILE: rtl/bmhq_ctrl.sv
`default_nettype none

module bmhq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire bmhq_pkg::op_e       op,
	input  wire bmhq_pkg::ctl_sts_t  sts,
	output      bmhq_pkg::ctl_cmd_t  cmd,
	output      logic                busy,
	output      logic                done
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_RD,
		S_UP_CMP,
		S_DN_LAST,
		S_DN_LOAD,
		S_DN_RD,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		cmd          = '0;
		cmd.err_code = bmhq_pkg::ERR_OK;
		state_nxt    = state_q;
		case (state_q)
			S_IDLE, S_DONE: begin
				state_nxt = S_IDLE;
				if (start) begin
					if (op == bmhq_pkg::OP_INSERT) begin
						if (sts.full) begin
							cmd.err_set  = 1'b1;
							cmd.err_code = bmhq_pkg::ERR_FULL;
							state_nxt    = S_DONE;
						end else begin
							cmd.ins_load = 1'b1;
							state_nxt    = S_UP_RD;
						end
					end else begin
						if (sts.empty) begin
							cmd.err_set  = 1'b1;
							cmd.err_code = bmhq_pkg::ERR_EMPTY;
							state_nxt    = S_DONE;
						end else begin
							cmd.del_load = 1'b1;
							state_nxt    = sts.one_left ? S_DONE : S_DN_LAST;
						end
					end
				end
			end
			S_UP_RD: begin
				if (sts.pos_zero) begin
					cmd.wr_val = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.rd_parent = 1'b1;
					state_nxt     = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (sts.up_less) begin
					cmd.wr_parent = 1'b1;
					state_nxt     = S_UP_RD;
				end else begin
					cmd.wr_val = 1'b1;
					state_nxt  = S_DONE;
				end
			end
			S_DN_LAST: begin
				cmd.rd_last = 1'b1;
				state_nxt   = S_DN_LOAD;
			end
			S_DN_LOAD: begin
				cmd.last_load = 1'b1;
				state_nxt     = S_DN_RD;
			end
			S_DN_RD: begin
				if (!sts.left_valid) begin
					cmd.wr_val = 1'b1;
					state_nxt  = S_DONE;
				end else begin
					cmd.rd_children = 1'b1;
					state_nxt       = S_DN_CMP;
				end
			end
			S_DN_CMP: begin
				if (sts.down_less) begin
					cmd.wr_big = 1'b1;
					state_nxt  = S_DN_RD;
				end else begin
					cmd.wr_val = 1'b1;
					state_nxt  = S_DONE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			busy_q  <= (state_nxt != S_IDLE) && (state_nxt != S_DONE);
			done_q  <= state_nxt == S_DONE;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy_q) |=> (busy_q || done_q))
		else $error("accepted word neither in work nor finished");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.wr_val, cmd.wr_parent, cmd.wr_big}))
		else $error("more than one write source in a cycle");

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("result strobe while still busy");

endmodule

`default_nettype wire

FILE: tb/sv/binary_max_heap_queue_core_tb.sv
`default_nettype none

module binary_max_heap_queue_core_tb;

	import bmhq_pkg::*;

	localparam int unsigned DEPTH = 128;
	localparam int TOTAL_WORDS  = 1020;
	localparam int CALM_TAIL    = 100;   // last words go in back to back
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT  = 2000;

	// shadow heap: predicts the result of every accepted word
	class heap_scoreboard;
		logic signed [VALUE_W-1:0] slots [DEPTH];
		int unsigned fill;
		rsp_t due[$];
		int unsigned failures;

		// new value goes at the end and climbs past smaller parents
		function void sift_in(logic signed [VALUE_W-1:0] v);
			int unsigned pos;
			int unsigned up;
			pos = fill;
			fill++;
			while (pos > 0) begin
				up = (pos - 1) / 2;
				if (!(slots[up] < v))
					break;
				slots[pos] = slots[up];
				pos = up;
			end
			slots[pos] = v;
		endfunction

		// last entry to the root, then sink it below the larger child (right on a tie)
		function void drop_max();
			int unsigned pos;
			int unsigned left;
			int unsigned right;
			int unsigned big;
			logic signed [VALUE_W-1:0] t;
			fill--;
			if (fill == 0)
				return;
			slots[0] = slots[fill];
			pos = 0;
			forever begin
				left = 2 * pos + 1;
				right = left + 1;
				if (left >= fill)
					break;
				big = left;
				if (right < fill && !(slots[right] < slots[left]))
					big = right;
				if (!(slots[pos] < slots[big]))
					break;
				t = slots[pos];
				slots[pos] = slots[big];
				slots[big] = t;
				pos = big;
			end
		endfunction

		function void note_word(req_t w);
			rsp_t e;
			e.error_code = ERR_OK;
			if (w.cmd == OP_INSERT) begin
				if (fill >= DEPTH)
					e.error_code = ERR_FULL;
				else
					sift_in(w.value);
			end else begin
				if (fill == 0)
					e.error_code = ERR_EMPTY;
				else
					drop_max();
			end
			e.top_value = (fill > 0) ? slots[0] : '0;
			e.entry_count = COUNT_W'(fill);
			e.is_empty = (fill == 0);
			due.push_back(e);
		endfunction

		function void report(string field, logic signed [63:0] want, logic signed [63:0] got);
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			failures++;
		endfunction

		function void check_result(rsp_t r);
			rsp_t e;
			if (due.size() == 0) begin
				$display("%0t: unexpected result, expected none, got top_value %0d count %0d",
					$time, r.top_value, r.entry_count);
				failures++;
				return;
			end
			e = due.pop_front();
			if (r.top_value !== e.top_value)
				report("top_value", e.top_value, r.top_value);
			if (r.entry_count !== e.entry_count)
				report("entry_count", e.entry_count, r.entry_count);
			if (r.is_empty !== e.is_empty)
				report("is_empty", e.is_empty, r.is_empty);
			if (r.error_code !== e.error_code)
				report("error_code", e.error_code, r.error_code);
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_t request = '0;
	logic busy;
	logic done;
	rsp_t result;

	heap_scoreboard sb = new;
	int level;          // entry count as the driver sees it, to steer fill and drain runs
	int words_sent;
	int idle_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	binary_max_heap_queue_core #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (VALUE_W)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.request (request),
		.busy    (busy),
		.done    (done),
		.result  (result)
	);

	// all sampling at the rising edge sees pre-edge values; result checked
	// before the new word is noted so a same-edge handoff keeps its order
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_result(result);
			if (start && !busy)
				sb.note_word(request);
		end
		if ((start && !busy) || done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin : watchdog
		wait (idle_cycles >= STALL_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	// hold start and the word until the block takes it, then maybe drop start for a while
	task automatic issue(op_e op, logic signed [VALUE_W-1:0] v, int gap);
		req_t w;
		w.cmd = op;
		w.value = v;
		start <= 1'b1;
		request <= w;
		do @(posedge clk); while (busy);
		if (op == OP_INSERT) begin
			if (level < DEPTH)
				level++;
		end else if (level > 0) begin
			level--;
		end
		words_sent++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// small values give plenty of ties, extremes hit the sign boundary
	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 16) - 8;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return 0;
					default: return -1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap(bit idle_on);
		if (!idle_on || words_sent >= TOTAL_WORDS - CALM_TAIL || $urandom_range(0, 1) == 0)
			return 0;
		return $urandom_range(1, 4);
	endfunction

	initial begin : stimulus
		bit idle_on;
		int ins_pct;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// delete on an empty heap, then extremes, ties and draining to empty
		issue(OP_DELETE, 32'sh12345678, 0);
		issue(OP_INSERT, 32'sh7fffffff, 1);
		issue(OP_INSERT, 32'sh80000000, 0);
		issue(OP_INSERT, 0, 2);
		issue(OP_INSERT, -1, 0);
		issue(OP_INSERT, 32'sh55555555, 0);
		issue(OP_INSERT, 32'shaaaaaaaa, 3);
		repeat (3) issue(OP_INSERT, 5, 0);
		repeat (9) issue(OP_DELETE, pick_value(), pick_gap(1'b1));
		issue(OP_DELETE, -1, 0);

		// random runs: fill past full, drain past empty, or mixed traffic
		while (words_sent < TOTAL_WORDS) begin
			idle_on = ($urandom_range(0, 2) != 0);
			case ($urandom_range(0, 4))
				0: begin
					while (level < DEPTH)
						issue(OP_INSERT, pick_value(), pick_gap(idle_on));
					repeat ($urandom_range(1, 3))
						issue(OP_INSERT, pick_value(), pick_gap(idle_on));
				end
				1: begin
					while (level > 0)
						issue(OP_DELETE, pick_value(), pick_gap(idle_on));
					repeat ($urandom_range(1, 3))
						issue(OP_DELETE, pick_value(), pick_gap(idle_on));
				end
				default: begin
					ins_pct = $urandom_range(30, 70);
					repeat (40)
						issue(op_e'(($urandom_range(1, 100) <= ins_pct) ? OP_INSERT : OP_DELETE),
							pick_value(), pick_gap(idle_on));
				end
			endcase
		end
		start <= 1'b0;

		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.failures == 0 && sb.due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire
